FILE: design/rocket_recovery_sequencer_defines.svh
// Assertion macros shared by the recovery sequencer RTL.
`ifndef ROCKET_RECOVERY_SEQUENCER_DEFINES_SVH
`define ROCKET_RECOVERY_SEQUENCER_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property on every rising edge, outside reset.
`define RRS_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("rrs assertion failed");
// Check that a condition holds in the cycle after a trigger.
`define RRS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("rrs assertion failed");
`else
`define RRS_ASSERT(lbl, clk, rstn, prop)
`define RRS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

FILE: design/rrs_pkg.sv
// Types, codes and saturating arithmetic for the recovery sequencer.
`default_nettype none

package rrs_pkg;

	localparam int MAX_RESULTS = 8;

	typedef logic signed [23:0] alt_t;

	typedef enum logic [2:0] {
		MODE_READY     = 3'd0,
		MODE_FLYING    = 3'd1,
		MODE_DROGUE    = 3'd2,
		MODE_MAIN      = 3'd3,
		MODE_RECOVERED = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		KIND_STATUS  = 3'd0,
		KIND_ALT     = 3'd1,
		KIND_APOGEE  = 3'd2,
		KIND_ERASE   = 3'd3,
		KIND_REPLAY  = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_SHORT  = 2'd1,
		OP_LONG   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	localparam logic [2:0] CFG_LIFTOFF  = 3'd0;
	localparam logic [2:0] CFG_DROP     = 3'd1;
	localparam logic [2:0] CFG_MAIN_ALT = 3'd2;
	localparam logic [2:0] CFG_LANDED   = 3'd3;
	localparam logic [2:0] CFG_LOG_FULL = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC,
		ST_DECIDE,
		ST_EMIT1,
		ST_EMIT2,
		ST_ROT
	} state_t;

	// Control word for the window row.
	typedef struct packed {
		logic clear;
		logic shift;
	} chain_ctl_t;

	function automatic alt_t sat24(input logic signed [24:0] v);
		if (v[24] != v[23]) begin
			return v[24] ? 24'sh800000 : 24'sh7FFFFF;
		end
		return v[23:0];
	endfunction

	function automatic alt_t sat_sub(input alt_t a, input alt_t b);
		logic signed [24:0] d;
		d = {a[23], a} - {b[23], b};
		return sat24(d);
	endfunction

	function automatic alt_t sat_add(input alt_t a, input alt_t b);
		logic signed [24:0] s;
		s = {a[23], a} + {b[23], b};
		return sat24(s);
	endfunction

endpackage

`default_nettype wire

FILE: design/rocket_recovery_sequencer.sv
// Top level of the rocket recovery sequencer: control, flight state and result register.
// Flow: a word is accepted in idle; its first result goes into the output register through
// the spread, decision and emit states, and a second apogee result from its own emit state.
// A new item is taken only in idle, once the last one is done; on liftoff the window row
// makes one full rotation through the shared rebase subtractor.
// Reset: asynchronous, clears the window, baseline, apogee; mode ready, default thresholds.
`default_nettype none
`include "rocket_recovery_sequencer_defines.svh"

module rocket_recovery_sequencer #(
	parameter int WINDOW = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic signed [23:0] sample_altitude,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic signed [23:0] record_value,
	output logic [2:0]  mode,
	output logic        drogue_fire,
	output logic        main_fire,
	output logic        last
);
	import rrs_pkg::*;

	localparam int IdxW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int FirstEmit = (WINDOW > MAX_RESULTS) ? WINDOW - MAX_RESULTS : 0;
	localparam logic [IdxW-1:0] IdxFirst = IdxW'(FirstEmit);
	localparam logic [IdxW-1:0] IdxLast  = IdxW'(WINDOW - 1);

	// control and flight state
	state_t state_q, state_d;
	mode_t  mode_q;
	alt_t   baseline_q;
	alt_t   apogee_q;
	logic [IdxW-1:0] idx_q;

	// configuration registers
	logic [22:0] liftoff_q;
	logic [22:0] drop_q;
	alt_t        main_alt_q;
	logic [22:0] landed_q;

	// per-item working registers
	op_t         op_q;
	logic        push_q;
	logic [23:0] spread_q;
	alt_t        w0_q;
	kind_t       kind1_q;
	alt_t        val1_q;
	logic        two_q;

	// result register
	logic  out_valid_q;
	kind_t kind_out_q;
	alt_t  value_out_q;
	mode_t mode_out_q;
	logic  last_out_q;

	// datapath
	chain_ctl_t chain_ctl;
	alt_t       chain_tail_in;
	alt_t       head;
	alt_t       tail;

	logic              accept;
	logic              cfg_write;
	logic              push_now;
	logic              out_free;
	logic              out_load;
	kind_t             out_kind_d;
	alt_t              out_value_d;
	logic              out_last_d;
	logic signed [24:0] diff;
	logic [24:0]       mag;
	logic signed [24:0] fall;
	logic              liftoff_hit;
	logic              landed_hit;
	logic              drop_hit;
	logic              main_hit;
	logic              erase_now;
	alt_t              reb;
	logic              rot_emit;
	logic              rot_adv;

	rrs_chain #(
		.WINDOW (WINDOW)
	) u_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (chain_ctl),
		.tail_in (chain_tail_in),
		.head    (head),
		.tail    (tail)
	);

	// Handshake decode. Configuration wins over a pending item in idle.
	assign accept    = in_valid && !in_stall;
	assign cfg_write = cfg_valid && cfg_ready;
	assign push_now  = accept && (operation == OP_SAMPLE) && (mode_q != MODE_RECOVERED);
	assign out_free  = !out_valid_q || !out_stall;

	// Spread of the window: newest minus oldest, as a magnitude.
	assign diff = {tail[23], tail} - {head[23], head};
	assign mag  = diff[24] ? 25'(-diff) : 25'(diff);

	// Drop below apogee; apogee already includes the newest sample, so it is not negative.
	assign fall = {apogee_q[23], apogee_q} - {tail[23], tail};

	assign liftoff_hit = spread_q > {1'b0, liftoff_q};
	assign landed_hit  = spread_q < {1'b0, landed_q};
	assign drop_hit    = $unsigned(fall) > {2'b00, drop_q};
	assign main_hit    = tail <= main_alt_q;
	assign erase_now   = !push_q && (mode_q == MODE_RECOVERED) && (op_q == OP_LONG);

	// Liftoff rotation: the head entry is rebased and goes back in at the tail.
	assign reb      = sat_sub(head, w0_q);
	assign rot_emit = idx_q >= IdxFirst;
	assign rot_adv  = !rot_emit || out_free;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_CALC;
				end
			end
			ST_CALC: begin
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (push_q && (mode_q == MODE_READY) && liftoff_hit) begin
					state_d = ST_ROT;
				end else begin
					state_d = ST_EMIT1;
				end
			end
			ST_EMIT1: begin
				if (out_free) begin
					state_d = two_q ? ST_EMIT2 : ST_IDLE;
				end
			end
			ST_EMIT2: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_ROT: begin
				if (rot_adv && (idx_q == IdxLast)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State outputs: handshakes, window control and the word for the result register.
	always_comb begin
		in_stall      = 1'b1;
		cfg_ready     = 1'b0;
		chain_ctl     = '0;
		chain_tail_in = sat_sub(sample_altitude, baseline_q);
		out_load      = 1'b0;
		out_kind_d    = kind1_q;
		out_value_d   = val1_q;
		out_last_d    = 1'b1;
		case (state_q)
			ST_IDLE: begin
				cfg_ready       = 1'b1;
				in_stall        = cfg_valid;
				chain_ctl.shift = push_now;
			end
			ST_CALC: begin
			end
			ST_DECIDE: begin
				chain_ctl.clear = erase_now;
			end
			ST_EMIT1: begin
				out_load   = out_free;
				out_last_d = !two_q;
			end
			ST_EMIT2: begin
				out_load    = out_free;
				out_kind_d  = KIND_APOGEE;
				out_value_d = apogee_q;
			end
			ST_ROT: begin
				chain_ctl.shift = rot_adv;
				chain_tail_in   = reb;
				out_load        = rot_adv && rot_emit;
				out_kind_d      = KIND_ALT;
				out_value_d     = reb;
				out_last_d      = idx_q == IdxLast;
			end
			default: begin
			end
		endcase
	end

	// Control, flight state and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MODE_READY;
			baseline_q  <= '0;
			apogee_q    <= '0;
			idx_q       <= '0;
			liftoff_q   <= 23'd1000;
			drop_q      <= 23'd500;
			main_alt_q  <= 24'sd20000;
			landed_q    <= 23'd200;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			// Hold the result word until taken; drop it once the far side takes it.
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			// The log-full flag only steers the mode between ready and recovered.
			if (cfg_write) begin
				case (cfg_index)
					CFG_LIFTOFF:  liftoff_q  <= cfg_data[22:0];
					CFG_DROP:     drop_q     <= cfg_data[22:0];
					CFG_MAIN_ALT: main_alt_q <= cfg_data;
					CFG_LANDED:   landed_q   <= cfg_data[22:0];
					CFG_LOG_FULL: begin
						if ((mode_q == MODE_READY) || (mode_q == MODE_RECOVERED)) begin
							mode_q <= cfg_data[0] ? MODE_RECOVERED : MODE_READY;
						end
					end
					default: begin
					end
				endcase
			end

			case (state_q)
				ST_CALC: begin
					// Track apogee in flight with the freshly pushed sample.
					if (push_q && (mode_q != MODE_READY) && (tail > apogee_q)) begin
						apogee_q <= tail;
					end
				end
				ST_DECIDE: begin
					if (push_q) begin
						case (mode_q)
							MODE_READY: begin
								if (liftoff_hit) begin
									baseline_q <= sat_add(baseline_q, head);
									mode_q     <= MODE_FLYING;
									idx_q      <= '0;
								end
							end
							MODE_FLYING: begin
								if (drop_hit) begin
									mode_q <= MODE_DROGUE;
								end
							end
							MODE_DROGUE: begin
								if (main_hit) begin
									mode_q <= MODE_MAIN;
								end
							end
							MODE_MAIN: begin
								if (landed_hit) begin
									mode_q <= MODE_RECOVERED;
								end
							end
							default: begin
							end
						endcase
					end else if (erase_now) begin
						baseline_q <= '0;
						apogee_q   <= '0;
						mode_q     <= MODE_READY;
					end
				end
				ST_ROT: begin
					// Apogee restarts at the oldest rebased entry, then keeps the maximum.
					if (rot_adv) begin
						if ((idx_q == '0) || (reb > apogee_q)) begin
							apogee_q <= reb;
						end
						idx_q <= idx_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Per-item working registers and the result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op_t'(operation);
			push_q <= push_now;
		end
		if (state_q == ST_CALC) begin
			spread_q <= mag[23:0];
		end
		if (state_q == ST_DECIDE) begin
			w0_q <= head;
			if (push_q && (mode_q != MODE_READY)) begin
				kind1_q <= KIND_ALT;
				val1_q  <= tail;
				two_q   <= (mode_q == MODE_DROGUE) && main_hit;
			end else begin
				val1_q <= '0;
				two_q  <= 1'b0;
				if (!push_q && (mode_q == MODE_RECOVERED) && (op_q == OP_SHORT)) begin
					kind1_q <= KIND_REPLAY;
				end else if (erase_now) begin
					kind1_q <= KIND_ERASE;
				end else begin
					kind1_q <= KIND_STATUS;
				end
			end
		end
		if (out_load) begin
			kind_out_q  <= out_kind_d;
			value_out_q <= out_value_d;
			mode_out_q  <= mode_q;
			last_out_q  <= out_last_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_out_q;
	assign record_value = value_out_q;
	assign mode         = mode_out_q;
	assign drogue_fire  = mode_out_q == MODE_DROGUE;
	assign main_fire    = mode_out_q == MODE_MAIN;
	assign last         = last_out_q;

	`RRS_ASSERT_NEXT(a_one_item, clk, arst_n, in_valid && !in_stall, in_stall)
	`RRS_ASSERT(a_cfg_not_item, clk, arst_n, cfg_valid && cfg_ready |-> in_stall)
	`RRS_ASSERT(a_rot_flying, clk, arst_n, state_q == ST_ROT |-> mode_q == MODE_FLYING)
	`RRS_ASSERT(a_apogee_main, clk, arst_n, state_q == ST_EMIT2 |-> mode_q == MODE_MAIN)

endmodule

`default_nettype wire

FILE: design/rrs_cell.sv
// One window entry: clears, holds or takes its neighbor's value.
`default_nettype none

module rrs_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  rrs_pkg::chain_ctl_t ctl,
	input  rrs_pkg::alt_t       shift_in,
	output rrs_pkg::alt_t       value
);
	import rrs_pkg::*;

	alt_t value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
		end else if (ctl.clear) begin
			value_q <= '0;
		end else if (ctl.shift) begin
			value_q <= shift_in;
		end
	end

	assign value = value_q;

endmodule

`default_nettype wire

FILE: design/rrs_chain.sv
// Row of window cells, oldest at the head, newest at the tail.
`default_nettype none

module rrs_chain #(
	parameter int WINDOW = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rrs_pkg::chain_ctl_t ctl,
	input  rrs_pkg::alt_t       tail_in,
	output rrs_pkg::alt_t       head,
	output rrs_pkg::alt_t       tail
);
	import rrs_pkg::*;

	alt_t entry [WINDOW];

	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		alt_t nbr;
		if (i == WINDOW - 1) begin : g_tail
			assign nbr = tail_in;
		end else begin : g_mid
			assign nbr = entry[i + 1];
		end
		rrs_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.shift_in (nbr),
			.value    (entry[i])
		);
	end

	assign head = entry[0];
	assign tail = entry[WINDOW - 1];

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// Testbench for the rocket recovery sequencer: directed flight table, random flights, scoreboard.
`timescale 1ns / 1ps

module testbench;
	import rrs_pkg::*;

	// Window depth of the block under test.
	localparam int DEPTH = 8;
	// Cycles to hold off after the last result before touching a register.
	localparam int HOLD = 2 * DEPTH + 8;
	// Cycle limit for the whole run.
	localparam int LIMIT = 400000;
	localparam int PHASES = 6;
	localparam int PHASE_WORDS = 55;
	localparam int ROWS = 25;
	localparam alt_t ALT_MAX = 24'sh7FFFFF;
	localparam alt_t ALT_MIN = 24'sh800000;

	// One result word as the block should deliver it.
	typedef struct {
		kind_t kind;
		alt_t  value;
		mode_t mode;
		logic  drogue_on;
		logic  main_on;
		logic  last_one;
	} chute_rec_t;

	// One row of the directed flight: the word, and for rows whose single result is
	// obvious, that result typed in.
	typedef struct packed {
		op_t   op;
		alt_t  alt;
		logic  typed;
		kind_t t_kind;
		mode_t t_mode;
	} flight_row_t;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_RANDOM,
		STALL_SHORT,
		STALL_LONG
	} stall_style_t;

	logic clk;
	logic arst_n = 1'b0;

	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = CFG_LIFTOFF;
	logic [23:0] cfg_data = '0;

	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  operation = OP_SAMPLE;
	logic signed [23:0] sample_altitude = '0;

	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  kind;
	logic signed [23:0] record_value;
	logic [2:0]  mode;
	logic        drogue_fire;
	logic        main_fire;
	logic        last;

	rocket_recovery_sequencer #(.WINDOW(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.sample_altitude(sample_altitude),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.record_value(record_value),
		.mode(mode),
		.drogue_fire(drogue_fire),
		.main_fire(main_fire),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Flight predictor: its own copy of the registers and the flight state.
	// ------------------------------------------------------------------
	logic [22:0] lift_thr   = 23'd1000;
	logic [22:0] drop_thr   = 23'd500;
	alt_t        main_alt   = 24'sd20000;
	logic [22:0] landed_thr = 23'd200;
	logic        log_full   = 1'b0;

	mode_t fm = MODE_READY;
	alt_t  win [DEPTH];
	alt_t  base = '0;
	alt_t  apex = '0;

	// Results of the word just accepted, then the words still owed by the block.
	chute_rec_t fresh[$];
	chute_rec_t due_records[$];

	int mismatches = 0;
	int cycles = 0;

	// Clamp a wide value to the 24 bit altitude range.
	function automatic alt_t clip_alt(input longint v);
		if (v > longint'(ALT_MAX)) return ALT_MAX;
		if (v < longint'(ALT_MIN)) return ALT_MIN;
		return alt_t'(v);
	endfunction

	// Absolute distance between newest and oldest window entry.
	function automatic longint window_span();
		longint d;
		d = longint'(win[DEPTH-1]) - longint'(win[0]);
		return d < 0 ? -d : d;
	endfunction

	function void add_record(input kind_t k, input alt_t v);
		chute_rec_t r;
		r.kind = k;
		r.value = v;
		r.mode = MODE_READY;
		r.drogue_on = 1'b0;
		r.main_on = 1'b0;
		r.last_one = 1'b0;
		fresh.push_back(r);
	endfunction

	function void clear_flight();
		for (int i = 0; i < DEPTH; i++) win[i] = '0;
		base = '0;
		apex = '0;
	endfunction

	// Update one register as the block does on a config write.
	function void apply_reg(input logic [2:0] idx, input logic [23:0] data);
		case (idx)
			CFG_LIFTOFF:  lift_thr = data[22:0];
			CFG_DROP:     drop_thr = data[22:0];
			CFG_MAIN_ALT: main_alt = alt_t'(data);
			CFG_LANDED:   landed_thr = data[22:0];
			CFG_LOG_FULL: begin
				log_full = data[0];
				if (fm == MODE_READY || fm == MODE_RECOVERED)
					fm = log_full ? MODE_RECOVERED : MODE_READY;
			end
			default: ;
		endcase
	endfunction

	// Advance the flight state by one accepted word; leave its results in fresh.
	function void advance_flight(input op_t op, input alt_t raw);
		alt_t w0;
		alt_t cur;
		longint d;
		int first;
		fresh.delete();
		first = DEPTH > MAX_RESULTS ? DEPTH - MAX_RESULTS : 0;
		if (op == OP_SAMPLE && fm != MODE_RECOVERED) begin
			for (int i = 0; i < DEPTH - 1; i++) win[i] = win[i+1];
			win[DEPTH-1] = clip_alt(longint'(raw) - longint'(base));
			if (fm == MODE_READY) begin
				if (window_span() > longint'(lift_thr)) begin
					// Liftoff: re-zero on the oldest entry and dump the rebased window.
					w0 = win[0];
					base = clip_alt(longint'(base) + longint'(w0));
					for (int i = 0; i < DEPTH; i++) begin
						win[i] = clip_alt(longint'(win[i]) - longint'(w0));
						if (i == 0 || win[i] > apex) apex = win[i];
						if (i >= first) add_record(KIND_ALT, win[i]);
					end
					fm = MODE_FLYING;
				end
			end else begin
				cur = win[DEPTH-1];
				if (cur > apex) apex = cur;
				add_record(KIND_ALT, cur);
				case (fm)
					MODE_FLYING: begin
						d = longint'(apex) - longint'(cur);
						if (d > longint'(drop_thr)) fm = MODE_DROGUE;
					end
					MODE_DROGUE: begin
						if (cur <= main_alt) begin
							add_record(KIND_APOGEE, apex);
							fm = MODE_MAIN;
						end
					end
					default: begin
						if (window_span() < longint'(landed_thr)) fm = MODE_RECOVERED;
					end
				endcase
			end
		end else if (fm == MODE_RECOVERED && op == OP_SHORT) begin
			add_record(KIND_REPLAY, '0);
		end else if (fm == MODE_RECOVERED && op == OP_LONG) begin
			add_record(KIND_ERASE, '0);
			clear_flight();
			fm = MODE_READY;
		end
		if (fresh.size() == 0) add_record(KIND_STATUS, '0);
		foreach (fresh[i]) begin
			fresh[i].mode = fm;
			fresh[i].drogue_on = (fm == MODE_DROGUE);
			fresh[i].main_on = (fm == MODE_MAIN);
			fresh[i].last_one = (i == fresh.size() - 1);
		end
	endfunction

	// ------------------------------------------------------------------
	// Input side: bursts of words separated by random gaps.
	// ------------------------------------------------------------------
	int burst_left = 0;

	task automatic send_word(input op_t op, input alt_t alt, input logic typed,
			input kind_t t_kind, input mode_t t_mode);
		int gap;
		chute_rec_t r;
		if (burst_left == 0) begin
			// Open a new burst, mostly after a gap, sometimes back to back.
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 16);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b1;
		operation <= op;
		sample_altitude <= alt;
		// Hold the word until the block takes it.
		do @(posedge clk); while (in_stall);
		burst_left--;
		advance_flight(op, alt);
		if (typed) begin
			r.kind = t_kind;
			r.value = '0;
			r.mode = t_mode;
			r.drogue_on = (t_mode == MODE_DROGUE);
			r.main_on = (t_mode == MODE_MAIN);
			r.last_one = 1'b1;
			due_records.push_back(r);
		end else begin
			foreach (fresh[i]) due_records.push_back(fresh[i]);
		end
	endtask

	// Drop valid, drain every owed result, then give the block time to go idle.
	task automatic settle();
		in_valid <= 1'b0;
		burst_left = 0;
		while (due_records.size() != 0) @(posedge clk);
		repeat (HOLD) @(posedge clk);
	endtask

	// Present one register write; valid stays high for the next one.
	task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, data);
	endtask

	task automatic program_limits(input logic [23:0] lift, input logic [23:0] drop,
			input logic [23:0] main_w, input logic [23:0] landed, input logic full);
		write_reg(CFG_LIFTOFF, lift);
		write_reg(CFG_DROP, drop);
		write_reg(CFG_MAIN_ALT, main_w);
		write_reg(CFG_LANDED, landed);
		write_reg(CFG_LOG_FULL, {23'd0, full});
		cfg_valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Random flight generator: follows the predicted mode so most words
	// form a plausible flight, with some raw noise mixed in.
	// ------------------------------------------------------------------
	longint alt_cur = 0;
	longint pad = 0;
	logic climbing = 1'b0;

	function automatic longint jitter(input int span);
		return longint'($urandom_range(0, 2 * span)) - span;
	endfunction

	task automatic pick_word(output op_t op, output alt_t alt);
		int roll;
		roll = $urandom_range(0, 99);
		op = OP_SAMPLE;
		if (roll < 8) begin
			// Raw noise: any operation, any altitude.
			op = op_t'($urandom_range(0, 3));
			alt = alt_t'($urandom);
			return;
		end
		case (fm)
			MODE_READY: begin
				if (climbing) alt_cur += $urandom_range(100, 2500);
				else if (roll < 80) alt_cur = pad + jitter(50);
				else climbing = 1'b1;
			end
			MODE_FLYING: begin
				climbing = 1'b0;
				if (roll < 70) alt_cur += $urandom_range(0, 4000);
				else alt_cur -= $urandom_range(0, 1500);
			end
			MODE_DROGUE: begin
				if (roll < 13) alt_cur = longint'(ALT_MIN);
				else alt_cur -= $urandom_range(500, 8000);
			end
			MODE_MAIN: begin
				if (roll < 20) alt_cur -= $urandom_range(0, 500);
				else alt_cur += jitter(30);
			end
			default: begin
				if (roll < 40) op = OP_SHORT;
				else if (roll < 55) op = OP_NONE;
				else if (roll < 70) alt_cur += jitter(100);
				else begin
					op = OP_LONG;
					pad = jitter(100000);
					alt_cur = pad;
					climbing = 1'b0;
				end
			end
		endcase
		alt_cur = longint'(clip_alt(alt_cur));
		alt = alt_t'(alt_cur);
	endtask

	// ------------------------------------------------------------------
	// Result side: stall on a pattern that is picked anew at random from time to time.
	// ------------------------------------------------------------------
	stall_style_t stall_style = STALL_NONE;
	int stall_tick = 0;

	always @(posedge clk) begin
		stall_tick <= stall_tick + 1;
		if (stall_tick % 64 == 0) stall_style <= stall_style_t'($urandom_range(0, 3));
		case (stall_style)
			STALL_NONE:   out_stall <= 1'b0;
			STALL_RANDOM: out_stall <= ($urandom_range(0, 99) < 40);
			STALL_SHORT:  out_stall <= (stall_tick % 7) < 3;
			default:      out_stall <= (stall_tick % 23) < 12;
		endcase
	end

	// Compare every accepted result word with the oldest one owed.
	always @(posedge clk) begin
		chute_rec_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (due_records.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: kind %0d value %0d mode %0d", kind,
						record_value, mode);
			end else begin
				want = due_records.pop_front();
				if (kind !== want.kind || record_value !== want.value || mode !== want.mode
						|| drogue_fire !== want.drogue_on || main_fire !== want.main_on
						|| last !== want.last_one) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: kind %0d/%0d value %0d/%0d mode %0d/%0d drogue %0b/%0b main %0b/%0b last %0b/%0b (expected/actual)",
							want.kind, kind, want.value, record_value, want.mode, mode,
							want.drogue_on, drogue_fire, want.main_on, main_fire,
							want.last_one, last);
				end
			end
		end
	end

	// Guard against a hang anywhere in the run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Directed flight under the reset thresholds: buttons on the pad, the
	// liftoff threshold edge, apogee at full scale, a drop of exactly the
	// drogue distance, a fall to the most negative altitude, main at the
	// deploy altitude itself, landing, replay, erase and a fresh liftoff.
	// ------------------------------------------------------------------
	flight_row_t flight_rows [ROWS] = '{
		'{OP_SHORT,  24'sd0,          1'b1, KIND_STATUS, MODE_READY},
		'{OP_LONG,   24'sd0,          1'b1, KIND_STATUS, MODE_READY},
		'{OP_NONE,   ALT_MAX,         1'b1, KIND_STATUS, MODE_READY},
		'{OP_SAMPLE, 24'sd0,          1'b1, KIND_STATUS, MODE_READY},
		'{OP_SAMPLE, 24'sd500,        1'b1, KIND_STATUS, MODE_READY},
		'{OP_SAMPLE, 24'sd1000,       1'b1, KIND_STATUS, MODE_READY},
		'{OP_SAMPLE, 24'sd1001,       1'b0, KIND_STATUS, MODE_READY},
		'{OP_SAMPLE, 24'sd5000,       1'b0, KIND_STATUS, MODE_READY},
		'{OP_SAMPLE, ALT_MAX,         1'b0, KIND_STATUS, MODE_READY},
		'{OP_SAMPLE, 24'sh7FFE0B,     1'b0, KIND_STATUS, MODE_READY},
		'{OP_SAMPLE, ALT_MIN,         1'b0, KIND_STATUS, MODE_READY},
		'{OP_SAMPLE, 24'sd30000,      1'b0, KIND_STATUS, MODE_READY},
		'{OP_SAMPLE, 24'sd20000,      1'b0, KIND_STATUS, MODE_READY},
		'{OP_SAMPLE, 24'sd19950,      1'b0, KIND_STATUS, MODE_READY},
		'{OP_SAMPLE, 24'sd19950,      1'b0, KIND_STATUS, MODE_READY},
		'{OP_SAMPLE, 24'sd19950,      1'b0, KIND_STATUS, MODE_READY},
		'{OP_SAMPLE, 24'sd19950,      1'b0, KIND_STATUS, MODE_READY},
		'{OP_SAMPLE, 24'sd19950,      1'b0, KIND_STATUS, MODE_READY},
		'{OP_SAMPLE, 24'sd19950,      1'b0, KIND_STATUS, MODE_READY},
		'{OP_SAMPLE, 24'sd19950,      1'b0, KIND_STATUS, MODE_READY},
		'{OP_SAMPLE, 24'sd19950,      1'b1, KIND_STATUS, MODE_RECOVERED},
		'{OP_SHORT,  24'sd0,          1'b1, KIND_REPLAY, MODE_RECOVERED},
		'{OP_NONE,   ALT_MIN,         1'b1, KIND_STATUS, MODE_RECOVERED},
		'{OP_LONG,   24'sd0,          1'b1, KIND_ERASE,  MODE_READY},
		'{OP_SAMPLE, ALT_MIN,         1'b0, KIND_STATUS, MODE_READY}
	};

	initial begin
		op_t op;
		alt_t alt;
		int main_pick;
		clear_flight();
		// Hold reset, then release it on an edge.
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Rewrite the reset thresholds so the directed flight runs on them.
		program_limits(24'd1000, 24'd500, 24'd20000, 24'd200, 1'b0);
		foreach (flight_rows[i])
			send_word(flight_rows[i].op, flight_rows[i].alt, flight_rows[i].typed,
				flight_rows[i].t_kind, flight_rows[i].t_mode);

		for (int phase = 0; phase < PHASES; phase++) begin
			settle();
			case (phase)
				0: program_limits(24'd1000, 24'd500, 24'd20000, 24'd200, 1'b0);
				// Lowest liftoff and drop thresholds, highest landing threshold, deploy only at the floor, log full.
				1: program_limits(24'd0, 24'd0, ALT_MIN, 24'h7FFFFF, 1'b1);
				// Highest liftoff and drop thresholds, deploy at once, never land.
				2: program_limits(24'hFFFFFF, 24'hFFFFFF, ALT_MAX, 24'h800000, 1'b0);
				default: begin
					main_pick = $urandom_range(0, 70000) - 10000;
					program_limits({1'($urandom_range(0, 1)), 23'($urandom_range(100, 5000))},
						{1'($urandom_range(0, 1)), 23'($urandom_range(50, 3000))},
						24'(main_pick),
						{1'($urandom_range(0, 1)), 23'($urandom_range(20, 500))},
						1'($urandom_range(0, 1)));
				end
			endcase
			pad = jitter(100000);
			alt_cur = pad;
			climbing = 1'b0;
			for (int n = 0; n < PHASE_WORDS; n++) begin
				pick_word(op, alt);
				send_word(op, alt, 1'b0, KIND_STATUS, MODE_READY);
			end
		end

		settle();
		if (mismatches == 0 && due_records.size() == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
